// ----- hdl/sdw_pkg.sv -----
// sdw_pkg: shared types and constants for the sine displacement warp
// holds field widths, fixed-point constants and the horner divider tables
// no dependencies
`default_nettype none

package sdw_pkg;

   localparam int POINT_BITS = 12;
   localparam int WARP_BITS  = 22;

   typedef logic [POINT_BITS-1:0]       point_type;
   typedef logic signed [WARP_BITS-1:0] warp_type;

   localparam logic [31:0] TURN_PER_RAD = 32'd683565276;
   localparam logic [30:0] HALF_PI      = 31'd1686629713;
   localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   localparam int HORNER_STEPS = 5;
   localparam int RECIP_SHIFT  = 34;

   // series divisors and floor(2^34 / divisor)
   localparam logic [7:0]  HORNER_DIV [HORNER_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] =
      '{32'd156180628, 32'd238609294, 32'd409044504, 32'd858993459, 32'd2863311530};

   // phase, fold, square, three per horner step, final product
   localparam int SIN_LAT = 3 + 3 * HORNER_STEPS + 1;

endpackage

`default_nettype wire

// ----- hdl/sine_displacement_warp_3d_unit.sv -----
// sine_displacement_warp_3d_unit: top level of the sinusoidal point warp
// six sdw_sine pipelines, displacement sum and rounding; depends on sdw_pkg
//
//   channel | ports                                  | direction
//   req     | req_valid req_stall req_point_x/y/z    | beat in
//   rsp     | rsp_valid rsp_stall rsp_warped_x/y/z   | beat out
//   csr     | csr_write_enable csr_write_data        | mode write
//
// one beat per cycle while no result is held by rsp_stall; latency is set by the
// sine pipeline (three stages per horner step) plus sum and rounding stages
// reset clears the valid bits and selects 3-d mode
// a stalled result freezes the whole pipeline and req_stall follows
`default_nettype none

module sine_displacement_warp_3d_unit #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sdw_pkg::point_type req_point_x,
   input  wire sdw_pkg::point_type req_point_y,
   input  wire sdw_pkg::point_type req_point_z,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sdw_pkg::warp_type      rsp_warped_x,
   output sdw_pkg::warp_type      rsp_warped_y,
   output sdw_pkg::warp_type      rsp_warped_z,
   input  wire logic              csr_write_enable,
   input  wire logic              csr_write_data
);

   localparam int LAT = sdw_pkg::SIN_LAT;
   localparam int VW  = COORD_BITS + 32;
   localparam int SH  = 30 - FRAC_BITS;
   localparam int WB  = sdw_pkg::WARP_BITS;

   logic enable;
   logic mode_ff;

   logic [31:0] ext_x, ext_y, ext_z;
   logic [COORD_BITS-1:0] cx, cy, cz;

   logic [COORD_BITS-1:0] x_ff [LAT];
   logic [COORD_BITS-1:0] y_ff [LAT];
   logic [COORD_BITS-1:0] z_ff [LAT];
   logic                  vld_ff [LAT+1];

   logic signed [31:0] sin_y32, sin_x32, cos_z16, sin_z8, sin_x16, cos_y16;

   logic signed [35:0] dx_in, dy_in, dz_in;
   logic signed [35:0] dx_ff, dy_ff, dz_ff;
   logic [COORD_BITS-1:0] ox_ff, oy_ff, oz_ff;
   logic                  mode_d_ff;

   logic signed [VW-1:0] sum_x, sum_y, sum_z;
   logic signed [VW-1:0] sh_x, sh_y, sh_z;
   logic signed [VW-1:0] half;

   logic              rsp_valid_ff;
   sdw_pkg::warp_type wx_ff, wy_ff, wz_ff;

   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   assign ext_x = 32'(req_point_x);
   assign ext_y = 32'(req_point_y);
   assign ext_z = 32'(req_point_z);
   assign cx    = ext_x[COORD_BITS-1:0];
   assign cy    = ext_y[COORD_BITS-1:0];
   assign cz    = ext_z[COORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   sdw_sine #(.COORD_BITS(COORD_BITS), .SHIFT(5), .COSINE(1'b0)) u_sin_y32 (
      .clock(clock), .enable(enable), .coord(cy), .sine(sin_y32));
   sdw_sine #(.COORD_BITS(COORD_BITS), .SHIFT(5), .COSINE(1'b0)) u_sin_x32 (
      .clock(clock), .enable(enable), .coord(cx), .sine(sin_x32));
   sdw_sine #(.COORD_BITS(COORD_BITS), .SHIFT(4), .COSINE(1'b1)) u_cos_z16 (
      .clock(clock), .enable(enable), .coord(cz), .sine(cos_z16));
   sdw_sine #(.COORD_BITS(COORD_BITS), .SHIFT(3), .COSINE(1'b0)) u_sin_z8 (
      .clock(clock), .enable(enable), .coord(cz), .sine(sin_z8));
   sdw_sine #(.COORD_BITS(COORD_BITS), .SHIFT(4), .COSINE(1'b0)) u_sin_x16 (
      .clock(clock), .enable(enable), .coord(cx), .sine(sin_x16));
   sdw_sine #(.COORD_BITS(COORD_BITS), .SHIFT(4), .COSINE(1'b1)) u_cos_y16 (
      .clock(clock), .enable(enable), .coord(cy), .sine(cos_y16));

   // coordinate delay line matching the sine latency
   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0] <= cx;
         y_ff[0] <= cy;
         z_ff[0] <= cz;
         for (int i = 1; i < LAT; i++) begin
            x_ff[i] <= x_ff[i-1];
            y_ff[i] <= y_ff[i-1];
            z_ff[i] <= z_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i <= LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[LAT];
      end
   end

   // displacement sums
   always_comb begin
      dx_in = -(36'(sin_y32) <<< 1);
      dy_in = -(36'(sin_x32) <<< 3);
      dz_in = -(36'(sin_x16) <<< 1) + (36'(cos_y16) <<< 2);
      if (!mode_ff) begin
         dx_in = dx_in + (36'(cos_z16) <<< 1);
         dy_in = dy_in + (36'(sin_z8) <<< 2);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         dz_ff     <= dz_in;
         ox_ff     <= x_ff[LAT-1];
         oy_ff     <= y_ff[LAT-1];
         oz_ff     <= z_ff[LAT-1];
         mode_d_ff <= mode_ff;
      end
   end

   // round to nearest, halves up
   assign half  = VW'(1) <<< (SH - 1);
   assign sum_x = $signed(VW'(ox_ff) << 30) + VW'(dx_ff) + half;
   assign sum_y = $signed(VW'(oy_ff) << 30) + VW'(dy_ff) + half;
   assign sum_z = $signed(VW'(oz_ff) << 30) + VW'(dz_ff) + half;
   assign sh_x  = sum_x >>> SH;
   assign sh_y  = sum_y >>> SH;
   assign sh_z  = sum_z >>> SH;

   always_ff @(posedge clock) begin
      if (enable) begin
         wx_ff <= sh_x[WB-1:0];
         wy_ff <= sh_y[WB-1:0];
         wz_ff <= mode_d_ff ? '0 : sh_z[WB-1:0];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_warped_x = wx_ff;
   assign rsp_warped_y = wy_ff;
   assign rsp_warped_z = wz_ff;

endmodule

`default_nettype wire

// ----- hdl/sdw_sine.sv -----
// sdw_sine: pipelined fixed-point sine or cosine of coord / 2^SHIFT, Q30 result
// phase, quadrant fold, taylor series in horner form; depends on sdw_pkg
`default_nettype none

module sdw_sine #(
   parameter int COORD_BITS = 12,
   parameter int SHIFT      = 5,
   parameter bit COSINE     = 1'b0
) (
   input  wire logic                  clock,
   input  wire logic                  enable,
   input  wire logic [COORD_BITS-1:0] coord,
   output logic signed [31:0]         sine
);

   localparam int PW = COORD_BITS + 32;
   localparam int NS = sdw_pkg::HORNER_STEPS;

   logic [PW-1:0] phase_prod;
   logic [31:0]   phase_in, phase_ff;
   logic [31:0]   turn;
   logic [30:0]   fold;
   logic [61:0]   angle_prod;
   logic [30:0]   angle_in, angle_ff;
   logic          neg_ff;
   logic [61:0]   sq_prod;

   logic [31:0] sq_s   [NS+1];
   logic [30:0] term_s [NS+1];
   logic [30:0] ang_s  [NS+1];
   logic        neg_s  [NS+1];

   logic [61:0]        final_prod;
   logic [30:0]        mag;
   logic signed [31:0] sine_in, sine_ff;

   assign phase_prod = PW'(coord) * PW'(sdw_pkg::TURN_PER_RAD);
   assign phase_in   = phase_prod[SHIFT+31:SHIFT];

   assign turn = COSINE ? phase_ff + sdw_pkg::QUARTER_TURN : phase_ff;
   assign fold = turn[30] ? sdw_pkg::Q30_ONE - {1'b0, turn[29:0]} : {1'b0, turn[29:0]};
   assign angle_prod = 62'(fold) * 62'(sdw_pkg::HALF_PI);
   assign angle_in   = angle_prod[60:30];

   assign sq_prod = 62'(angle_ff) * 62'(angle_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         phase_ff  <= phase_in;
         angle_ff  <= angle_in;
         neg_ff    <= turn[31];
         sq_s[0]   <= sq_prod[61:30];
         term_s[0] <= sdw_pkg::Q30_ONE;
         ang_s[0]  <= angle_ff;
         neg_s[0]  <= neg_ff;
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_horner
      logic [62:0] mul_prod;
      logic [31:0] prod_in, prod_a_ff, prod_b_ff;
      logic [31:0] sq_a_ff, sq_b_ff;
      logic [30:0] ang_a_ff, ang_b_ff;
      logic        neg_a_ff, neg_b_ff;
      logic [63:0] recip_prod;
      logic [29:0] quo_in, quo_ff;
      logic [31:0] rem;
      logic [29:0] quo;

      assign mul_prod   = 63'(sq_s[k]) * 63'(term_s[k]);
      assign prod_in    = mul_prod[61:30];
      assign recip_prod = 64'(prod_a_ff) * 64'(sdw_pkg::HORNER_RECIP[k]);
      assign quo_in     = recip_prod[63:sdw_pkg::RECIP_SHIFT];
      assign rem        = prod_b_ff - 32'(quo_ff) * 32'(sdw_pkg::HORNER_DIV[k]);
      assign quo        = (rem >= 32'(sdw_pkg::HORNER_DIV[k])) ? quo_ff + 30'd1 : quo_ff;

      always_ff @(posedge clock) begin
         if (enable) begin
            prod_a_ff   <= prod_in;
            sq_a_ff     <= sq_s[k];
            ang_a_ff    <= ang_s[k];
            neg_a_ff    <= neg_s[k];
            quo_ff      <= quo_in;
            prod_b_ff   <= prod_a_ff;
            sq_b_ff     <= sq_a_ff;
            ang_b_ff    <= ang_a_ff;
            neg_b_ff    <= neg_a_ff;
            term_s[k+1] <= sdw_pkg::Q30_ONE - {1'b0, quo};
            sq_s[k+1]   <= sq_b_ff;
            ang_s[k+1]  <= ang_b_ff;
            neg_s[k+1]  <= neg_b_ff;
         end
      end
   end

   assign final_prod = 62'(ang_s[NS]) * 62'(term_s[NS]);
   assign mag        = final_prod[60:30];
   assign sine_in    = neg_s[NS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

   always_ff @(posedge clock) begin
      if (enable) begin
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

`default_nettype wire

// ----- hdl/sdw_checker.sv -----
// sdw_checker: port-level assertions for sine_displacement_warp_3d_unit
// bound to the top level below; depends on sdw_pkg
`default_nettype none

module sdw_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire sdw_pkg::warp_type rsp_warped_x,
   input wire sdw_pkg::warp_type rsp_warped_y,
   input wire sdw_pkg::warp_type rsp_warped_z
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_stall_only_on_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without output backpressure");

   a_backpressure_stalls: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("beat accepted while result held");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_warped_x)
         && $stable(rsp_warped_y) && $stable(rsp_warped_z)))
      else $error("held result changed");

endmodule

bind sine_displacement_warp_3d_unit sdw_checker u_sdw_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_warped_x(rsp_warped_x),
   .rsp_warped_y(rsp_warped_y),
   .rsp_warped_z(rsp_warped_z)
);

`default_nettype wire
